>>> rtl/core/timeout_ratio_circuit_breaker_defines.svh
// ----------------------------------------------------------------------------
// Timeout ratio circuit breaker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMEOUT_RATIO_CIRCUIT_BREAKER_DEFINES_SVH
`define TIMEOUT_RATIO_CIRCUIT_BREAKER_DEFINES_SVH

// same-cycle implication
`define CTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Types and constants of the timeout ratio circuit breaker.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam logic OP_CALL  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAK_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUTS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_PERCENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_SECONDS  = 3'd4;

  localparam logic [31:0] RST_WINDOW_SECONDS = 32'd60;
  localparam logic [31:0] RST_STREAK_LIMIT   = 32'd5;
  localparam logic [31:0] RST_MIN_TIMEOUTS   = 32'd5;
  localparam logic [6:0]  RST_RATIO_PERCENT  = 7'd50;
  localparam logic [30:0] RST_RETRY_SECONDS  = 31'd30;

  localparam logic [31:0] EARLY_CLOSE_SECONDS = 32'd5;
  localparam logic [38:0] PERCENT_BASE        = 39'd100;

  typedef struct packed {
    logic        op;
    logic        timed_out;
    logic [31:0] now_seconds;
  } evt_t;

  typedef struct packed {
    logic granted;
    logic active;
  } res_t;

endpackage

>>> rtl/core/timeout_ratio_circuit_breaker.sv
// ----------------------------------------------------------------------------
// timeout_ratio_circuit_breaker: one event per cycle while the result side does not
// stall; each result passes the input register, then the result register.
// Throughput set by the single update pass on the state registers.
// Synchronous reset: link active, counters and timers zero, regs default.
// ----------------------------------------------------------------------------
module timeout_ratio_circuit_breaker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             evt_valid,
  output logic                             evt_stall,
  input  ctb_pkg::evt_t                    evt,
  output logic                             res_valid,
  input  logic                             res_stall,
  output ctb_pkg::res_t                    res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import ctb_pkg::*;

  logic [31:0] window_seconds;
  logic [31:0] streak_limit;
  logic [31:0] min_timeouts;
  logic [6:0]  ratio_percent;
  logic [30:0] retry_seconds;

  logic        active_flag;
  logic [31:0] call_count;
  logic [31:0] timeout_count;
  logic [31:0] fail_streak;
  logic [31:0] window_start;
  logic [31:0] last_retry;

  logic        active_flag_next;
  logic [31:0] call_count_next;
  logic [31:0] timeout_count_next;
  logic [31:0] fail_streak_next;
  logic [31:0] window_start_next;
  logic [31:0] last_retry_next;
  logic        granted_next;

  logic        s1_valid;
  evt_t        s1;
  logic        advance;

  logic [31:0] streak_inc;
  logic [31:0] calls_inc;
  logic [31:0] touts_inc;
  logic [31:0] elapsed;
  logic [31:0] since_retry;
  logic        win_close;
  logic [38:0] ratio_prod;
  logic [38:0] tout_scaled;
  logic        trip;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign evt_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= RST_WINDOW_SECONDS;
      streak_limit   <= RST_STREAK_LIMIT;
      min_timeouts   <= RST_MIN_TIMEOUTS;
      ratio_percent  <= RST_RATIO_PERCENT;
      retry_seconds  <= RST_RETRY_SECONDS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SECONDS: window_seconds <= cfg_data;
        REG_STREAK_LIMIT:   streak_limit   <= cfg_data;
        REG_MIN_TIMEOUTS:   min_timeouts   <= cfg_data;
        REG_RATIO_PERCENT:  ratio_percent  <= cfg_data[6:0];
        REG_RETRY_SECONDS:  retry_seconds  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    streak_inc  = (fail_streak == '1) ? fail_streak : fail_streak + 32'd1;
    calls_inc   = (call_count == '1) ? call_count : call_count + 32'd1;
    touts_inc   = (timeout_count == '1) ? timeout_count : timeout_count + 32'd1;
    elapsed     = s1.now_seconds - window_start;
    since_retry = s1.now_seconds - last_retry;

    active_flag_next   = active_flag;
    call_count_next    = call_count;
    timeout_count_next = timeout_count;
    fail_streak_next   = fail_streak;
    window_start_next  = window_start;
    last_retry_next    = last_retry;
    granted_next       = 1'b0;

    fail_streak_next   = s1.timed_out ? streak_inc : 32'd0;
    call_count_next    = calls_inc;
    timeout_count_next = s1.timed_out ? touts_inc : timeout_count;

    // floor(r*c/100) <= t  <=>  r*c <= 100*t + 99
    ratio_prod  = 39'(ratio_percent) * 39'(call_count_next);
    tout_scaled = 39'(timeout_count_next) * PERCENT_BASE + 39'd99;
    trip        = (timeout_count_next >= min_timeouts) && (ratio_prod <= tout_scaled);
    win_close   = (elapsed >= window_seconds) ||
                  ((fail_streak_next >= streak_limit) && (elapsed > EARLY_CLOSE_SECONDS));

    if (s1.op == OP_QUERY) begin
      call_count_next    = call_count;
      timeout_count_next = timeout_count;
      fail_streak_next   = fail_streak;
      if (active_flag || (since_retry >= {1'b0, retry_seconds})) begin
        granted_next    = 1'b1;
        last_retry_next = s1.now_seconds;
      end
    end else if (!active_flag) begin
      call_count_next    = call_count;
      timeout_count_next = timeout_count;
      if (!s1.timed_out) begin
        active_flag_next   = 1'b1;
        window_start_next  = s1.now_seconds;
        fail_streak_next   = 32'd0;
        call_count_next    = 32'd1;
        timeout_count_next = 32'd0;
      end
    end else if (win_close) begin
      window_start_next  = s1.now_seconds;
      call_count_next    = 32'd0;
      timeout_count_next = 32'd0;
      fail_streak_next   = 32'd0;
      if (trip) begin
        active_flag_next = 1'b0;
        last_retry_next  = s1.now_seconds;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      res_valid     <= 1'b0;
      active_flag   <= 1'b1;
      call_count    <= 32'd0;
      timeout_count <= 32'd0;
      fail_streak   <= 32'd0;
      window_start  <= 32'd0;
      last_retry    <= 32'd0;
    end else begin
      if (evt_valid && !evt_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid     <= 1'b1;
        active_flag   <= active_flag_next;
        call_count    <= call_count_next;
        timeout_count <= timeout_count_next;
        fail_streak   <= fail_streak_next;
        window_start  <= window_start_next;
        last_retry    <= last_retry_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      s1 <= evt;
    end
    if (advance) begin
      res.granted <= granted_next;
      res.active  <= active_flag_next;
    end
  end

endmodule

>>> rtl/core/ctb_checker.sv
// ----------------------------------------------------------------------------
// ctb_checker
// Port-level checks on the timeout ratio circuit breaker, bound to the top.
// ----------------------------------------------------------------------------
`include "timeout_ratio_circuit_breaker_defines.svh"

module ctb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          evt_valid,
  input logic                          evt_stall,
  input logic                          res_valid,
  input logic                          res_stall,
  input ctb_pkg::res_t                 res,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);
  import ctb_pkg::*;

  // input side backs up only behind a full, stalled result register
  `CTB_ASSERT_NOW(a_stall_cause, evt_stall, res_valid && res_stall, "stall without result stall")
  `CTB_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid, "result valid right after reset")
  `CTB_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "config transfer refused")
  `CTB_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result moved")

endmodule

bind timeout_ratio_circuit_breaker ctb_checker u_ctb_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: timeout ratio circuit breaker testbench
// Sends directed and random call/query events with random gaps and result
// stalls. A behavioral copy of the breaker predicts granted/active for each
// accepted event, and every result transfer is compared in order.
// ----------------------------------------------------------------------------
module tb;
  import ctb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 evt_valid = 1'b0;
  logic                 evt_stall;
  evt_t                 evt = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_t                 res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // breaker copy: configuration and state
  logic [31:0] win_len     = RST_WINDOW_SECONDS;
  logic [31:0] streak_lim  = RST_STREAK_LIMIT;
  logic [31:0] min_to      = RST_MIN_TIMEOUTS;
  logic [6:0]  ratio_pct   = RST_RATIO_PERCENT;
  logic [30:0] retry_gap   = RST_RETRY_SECONDS;
  logic        link_up     = 1'b1;
  logic [31:0] calls       = '0;
  logic [31:0] timeouts    = '0;
  logic [31:0] streak      = '0;
  logic [31:0] win_start   = '0;
  logic [31:0] last_retry  = '0;

  res_t        expected_res[$];
  res_t        want;
  int          errors = 0;
  int unsigned cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_req = 0;

  timeout_ratio_circuit_breaker u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      REG_WINDOW_SECONDS: win_len = data;
      REG_STREAK_LIMIT:   streak_lim = data;
      REG_MIN_TIMEOUTS:   min_to = data;
      REG_RATIO_PERCENT:  ratio_pct = data[6:0];
      REG_RETRY_SECONDS:  retry_gap = data[30:0];
      default: ;
    endcase
  endfunction

  function automatic res_t breaker_step(evt_t e);
    res_t        r;
    logic [31:0] elapsed;
    logic [63:0] ratio_floor;
    r.granted = 1'b0;
    if (e.op == OP_CALL) begin
      streak = e.timed_out ? sat_inc(streak) : 32'd0;
      if (!link_up) begin
        if (!e.timed_out) begin
          link_up   = 1'b1;
          win_start = e.now_seconds;
          streak    = '0;
          calls     = 32'd1;
          timeouts  = '0;
        end
      end else begin
        calls = sat_inc(calls);
        if (e.timed_out) timeouts = sat_inc(timeouts);
        elapsed = e.now_seconds - win_start;
        if (elapsed >= win_len || (streak >= streak_lim && elapsed > EARLY_CLOSE_SECONDS)) begin
          win_start   = e.now_seconds;
          ratio_floor = (64'(ratio_pct) * 64'(calls)) / 64'(PERCENT_BASE);
          if (timeouts >= min_to && 64'(timeouts) >= ratio_floor) begin
            link_up    = 1'b0;
            last_retry = e.now_seconds;
          end
          calls    = '0;
          timeouts = '0;
          streak   = '0;
        end
      end
    end else if (link_up || (e.now_seconds - last_retry) >= {1'b0, retry_gap}) begin
      last_retry = e.now_seconds;
      r.granted  = 1'b1;
    end
    r.active = link_up;
    return r;
  endfunction

  // result side: random stalls after each transfer, plus requested long hold-offs
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (res_valid && !res_stall) stall_left = rx_idle_en ? $urandom_range(0, 14) : 0;
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result granted=%b active=%b", $time, res.granted,
                 res.active);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (res.granted !== want.granted) begin
          $display("%0t: granted expected %b actual %b", $time, want.granted, res.granted);
          errors++;
        end
        if (res.active !== want.active) begin
          $display("%0t: active expected %b actual %b", $time, want.active, res.active);
          errors++;
        end
      end
    end
  end

  task automatic send_event(input logic op, input logic to, input logic [31:0] t);
    evt_t e;
    int   gap;
    e.op          = op;
    e.timed_out   = to;
    e.now_seconds = t;
    gap = tx_idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt       <= e;
    do @(posedge clk); while (evt_stall);
    expected_res.push_back(breaker_step(e));
  endtask

  task automatic drain_results();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] w, input logic [31:0] s, input logic [31:0] m,
                            input logic [31:0] r, input logic [31:0] t);
    drain_results();
    write_reg(REG_WINDOW_SECONDS, w);
    write_reg(REG_STREAK_LIMIT, s);
    write_reg(REG_MIN_TIMEOUTS, m);
    write_reg(REG_RATIO_PERCENT, r);
    write_reg(REG_RETRY_SECONDS, t);
  endtask

  // reset config: streak close, retry spacing, reactivation, wrap, exact 5 s boundary
  task automatic test_directed();
    send_event(OP_QUERY, 1'b0, 32'd0);
    send_event(OP_CALL, 1'b0, 32'd3);
    for (int i = 11; i <= 15; i++) send_event(OP_CALL, 1'b1, 32'(i));
    send_event(OP_QUERY, 1'b0, 32'd20);
    send_event(OP_QUERY, 1'b0, 32'd45);
    send_event(OP_QUERY, 1'b1, 32'd46);
    send_event(OP_CALL, 1'b1, 32'd50);
    send_event(OP_QUERY, 1'b0, 32'd75);
    send_event(OP_CALL, 1'b0, 32'd80);
    send_event(OP_CALL, 1'b0, 32'd10);
    for (int i = 11; i <= 16; i++) send_event(OP_CALL, 1'b1, 32'(i));
    send_event(OP_QUERY, 1'b1, 32'hFFFF_FFFF);
    send_event(OP_CALL, 1'b0, 32'hFFFF_FFF0);
    send_event(OP_QUERY, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(OP_CALL, 1'b0, 32'd100);
    send_event(OP_QUERY, 1'b0, 32'd100);
    send_event(OP_CALL, 1'b1, 32'd101);
    send_event(OP_CALL, 1'b0, 32'd101);
    send_event(OP_CALL, 1'b0, 32'd102);
    send_event(OP_QUERY, 1'b0, 32'd102);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd100, 32'hFFFF_FFFF);
    send_event(OP_CALL, 1'b0, 32'd200);
    for (int i = 0; i < 4; i++) send_event(OP_CALL, 1'b1, 32'd201 + i);
    send_event(OP_CALL, 1'b1, 32'd150);
    send_event(OP_QUERY, 1'b0, 32'd151);
    send_event(OP_QUERY, 1'b0, 32'h8000_0000);
    send_event(OP_QUERY, 1'b0, 32'd149);
    send_event(OP_CALL, 1'b0, 32'd300);
    set_config(32'd4, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7);
    drain_results();
    write_reg(REG_UNMAPPED, 32'd0);
    write_reg(REG_UNMAPPED + 3'd0 - 3'd2, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_event(OP_CALL, 1'b1, 32'd400 + 2 * i);
    set_config(32'd3, 32'd1, 32'd2, 32'd127, 32'd5);
    for (int i = 0; i < 12; i++) send_event(i % 3 == 2 ? OP_QUERY : OP_CALL, i % 4 != 0,
                                            32'd500 + i);
  endtask

  // result side held for a long stretch while events keep coming back to back
  task automatic test_backpressure();
    logic [31:0] t;
    set_config(32'd10, 32'd3, 32'd2, 32'd40, 32'd4);
    tx_idle_en  = 1'b0;
    rx_hold_req = 200;
    t = 32'd1000;
    for (int i = 0; i < 40; i++) begin
      t = t + $urandom_range(0, 3);
      send_event($urandom_range(0, 3) == 0 ? OP_QUERY : OP_CALL, 1'($urandom_range(0, 1)), t);
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    logic [31:0] t;
    t = 32'd2000;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 10; i++) begin
        t = t + $urandom_range(0, 4);
        send_event($urandom_range(0, 2) == 0 ? OP_QUERY : OP_CALL, 1'($urandom_range(0, 1)),
                   t);
      end
      drain_results();
    end
  endtask

  task automatic test_random_phases();
    logic [31:0] t;
    logic [31:0] w;
    logic [31:0] rt;
    int          to_pct;
    int          q_pct;
    int          step_sel;
    t = $urandom();
    for (int p = 0; p < 9; p++) begin
      w  = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0)
                                       : $urandom_range(0, 40);
      rt = ($urandom_range(0, 7) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 25);
      rt[31] = 1'($urandom_range(0, 1));
      set_config(w, $urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(0, 127), rt);
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      to_pct = $urandom_range(0, 100);
      q_pct  = $urandom_range(10, 50);
      for (int i = 0; i < 85; i++) begin
        step_sel = $urandom_range(0, 39);
        if (step_sel == 0) t = $urandom();
        else if (step_sel == 1) t = t - $urandom_range(1, 50);
        else t = t + $urandom_range(0, 6);
        send_event($urandom_range(0, 99) < q_pct ? OP_QUERY : OP_CALL,
                   $urandom_range(0, 99) < to_pct, t);
      end
    end
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_sender_pause();
    test_random_phases();
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
